### rtl/dof_pkg.sv
// ----------------------------------------------------------------------------
// DHCP option finder package
// Shared types and constants for the option finder: walk phases, result
// status codes, the walk state and the result record.
// ----------------------------------------------------------------------------
package dof_pkg;

	localparam int unsigned ByteW = 8;
	localparam logic [ByteW-1:0] CodePad = 8'd0;
	localparam logic [ByteW-1:0] CodeEnd = 8'd255;
	localparam logic [ByteW-1:0] WantedReset = 8'd53;

	typedef enum logic [1:0] {
		PH_CODE  = 2'd0,
		PH_LEN   = 2'd1,
		PH_VALUE = 2'd2,
		PH_WAIT  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_DATA     = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_TRUNC    = 2'd3
	} status_t;

	typedef struct packed {
		phase_t           phase;
		logic [ByteW-1:0] bytes_left;
		logic             in_match;
		logic [ByteW-1:0] held_length;
	} walk_state_t;

	typedef struct packed {
		logic [ByteW-1:0] value_byte;
		logic [ByteW-1:0] record_length;
		status_t          status;
		logic             run_last;
	} result_t;

endpackage

### rtl/dof_if.sv
// ----------------------------------------------------------------------------
// DHCP option finder channels
// Valid/ready channels for option bytes in and search results out.
// ----------------------------------------------------------------------------
interface dof_in_if;
	logic                       valid;
	logic                       ready;
	logic [dof_pkg::ByteW-1:0]  option_byte;
	logic                       area_last;

	modport source (output valid, output option_byte, output area_last, input ready);
	modport sink (input valid, input option_byte, input area_last, output ready);
endinterface

interface dof_out_if;
	logic                       valid;
	logic                       ready;
	logic [dof_pkg::ByteW-1:0]  value_byte;
	logic [dof_pkg::ByteW-1:0]  record_length;
	logic [1:0]                 status;
	logic                       run_last;

	modport source (output valid, output value_byte, output record_length,
		output status, output run_last, input ready);
	modport sink (input valid, input value_byte, input record_length,
		input status, input run_last, output ready);
endinterface

### rtl/dof_step.sv
// ----------------------------------------------------------------------------
// DHCP option finder step logic
// Given the walk state and one option byte, computes the next walk state and
// the result, if any, that the byte causes.
// ----------------------------------------------------------------------------
module dof_step (
	input  dof_pkg::walk_state_t         state,
	input  logic [dof_pkg::ByteW-1:0]    option_byte,
	input  logic                         area_last,
	input  logic [dof_pkg::ByteW-1:0]    wanted_code,
	output dof_pkg::walk_state_t         next_state,
	output logic                         res_valid,
	output dof_pkg::result_t             res
);

	dof_pkg::walk_state_t rearmed;
	logic [dof_pkg::ByteW-1:0] dec_left;
	logic                      match;

	always_comb begin
		rearmed = '0;
		rearmed.phase = dof_pkg::PH_CODE;
		dec_left = state.bytes_left - 8'd1;
		match = (option_byte == wanted_code);
	end

	always_comb begin
		next_state = state;
		res_valid = 1'b0;
		res = '0;
		res.status = dof_pkg::ST_DATA;

		unique case (state.phase)
			dof_pkg::PH_CODE: begin
				if (option_byte == dof_pkg::CodePad) begin
					if (area_last) begin
						next_state = rearmed;
						res_valid = 1'b1;
						res.status = dof_pkg::ST_NOTFOUND;
						res.run_last = 1'b1;
					end
				end else if (option_byte == dof_pkg::CodeEnd) begin
					if (area_last) begin
						next_state = rearmed;
					end else begin
						next_state.phase = dof_pkg::PH_WAIT;
					end
					res_valid = 1'b1;
					res.status = dof_pkg::ST_NOTFOUND;
					res.run_last = 1'b1;
				end else if (area_last) begin
					// Area ends right after a code byte: a matching code is cut short.
					next_state = rearmed;
					res_valid = 1'b1;
					res.status = match ? dof_pkg::ST_TRUNC : dof_pkg::ST_NOTFOUND;
					res.run_last = 1'b1;
				end else begin
					next_state.in_match = match;
					next_state.phase = dof_pkg::PH_LEN;
				end
			end
			dof_pkg::PH_LEN: begin
				if (state.in_match) begin
					next_state.held_length = option_byte;
					if (option_byte == '0) begin
						if (area_last) begin
							next_state = rearmed;
						end else begin
							next_state.phase = dof_pkg::PH_WAIT;
						end
						res_valid = 1'b1;
						res.status = dof_pkg::ST_EMPTY;
						res.run_last = 1'b1;
					end else if (area_last) begin
						next_state = rearmed;
						res_valid = 1'b1;
						res.record_length = option_byte;
						res.status = dof_pkg::ST_TRUNC;
						res.run_last = 1'b1;
					end else begin
						next_state.bytes_left = option_byte;
						next_state.phase = dof_pkg::PH_VALUE;
					end
				end else if (area_last) begin
					next_state = rearmed;
					res_valid = 1'b1;
					res.status = dof_pkg::ST_NOTFOUND;
					res.run_last = 1'b1;
				end else if (option_byte == '0) begin
					next_state.phase = dof_pkg::PH_CODE;
				end else begin
					next_state.bytes_left = option_byte;
					next_state.phase = dof_pkg::PH_VALUE;
				end
			end
			dof_pkg::PH_VALUE: begin
				next_state.bytes_left = dec_left;
				if (state.in_match) begin
					if (dec_left == '0) begin
						if (area_last) begin
							next_state = rearmed;
						end else begin
							next_state.phase = dof_pkg::PH_WAIT;
						end
						res_valid = 1'b1;
						res.value_byte = option_byte;
						res.record_length = state.held_length;
						res.status = dof_pkg::ST_DATA;
						res.run_last = 1'b1;
					end else if (area_last) begin
						// The value byte on this transaction is dropped.
						next_state = rearmed;
						res_valid = 1'b1;
						res.record_length = state.held_length;
						res.status = dof_pkg::ST_TRUNC;
						res.run_last = 1'b1;
					end else begin
						res_valid = 1'b1;
						res.value_byte = option_byte;
						res.record_length = state.held_length;
						res.status = dof_pkg::ST_DATA;
					end
				end else if (area_last) begin
					next_state = rearmed;
					res_valid = 1'b1;
					res.status = dof_pkg::ST_NOTFOUND;
					res.run_last = 1'b1;
				end else if (dec_left == '0) begin
					next_state.phase = dof_pkg::PH_CODE;
				end
			end
			dof_pkg::PH_WAIT: begin
				if (area_last) begin
					next_state = rearmed;
				end
			end
		endcase
	end

endmodule

### rtl/dof_out_reg.sv
// ----------------------------------------------------------------------------
// DHCP option finder result register
// Holds one result until the downstream side takes it; a new result may be
// loaded in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module dof_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  dof_pkg::result_t  res,
	output logic              free,
	dof_out_if.source         out_ch
);

	logic             valid_q;
	dof_pkg::result_t res_q;

	assign free = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= res;
		end
	end

	assign out_ch.valid = valid_q;
	assign out_ch.value_byte = res_q.value_byte;
	assign out_ch.record_length = res_q.record_length;
	assign out_ch.status = res_q.status;
	assign out_ch.run_last = res_q.run_last;

endmodule

### rtl/dhcp_option_finder.sv
// ----------------------------------------------------------------------------
// DHCP option finder
// Walks the code-length-value records of a DHCP options area, one byte per
// transaction, and reports the value bytes of the first record whose code
// matches the configured option code, or a found-empty, not-found or
// truncated status.
//
//   Channel  | Dir | Payload                                     | Handshake
//   ---------+-----+---------------------------------------------+----------
//   in_ch    | in  | option_byte[7:0], area_last                 | valid/ready
//   out_ch   | out | value_byte[7:0], record_length[7:0],        | valid/ready
//            |     | status[1:0], run_last                       |
//   cfg      | in  | cfg_wdata[7:0] (wanted code)                | cfg_we
//
// One byte per cycle while out_ch takes results; a result is presented on out_ch
// after its byte passes the input register, then the result register.
// Reset clears the walk state and loads the wanted code with 53.
// When the result register is full and not taken, a byte that causes a result
// waits in the input register, and in_ch.ready drops until it can move.
// ----------------------------------------------------------------------------
module dhcp_option_finder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [dof_pkg::ByteW-1:0]  cfg_wdata,
	dof_in_if.sink                     in_ch,
	dof_out_if.source                  out_ch
);

	logic [dof_pkg::ByteW-1:0] wanted_q;
	logic                      valid_s1;
	logic [dof_pkg::ByteW-1:0] byte_s1;
	logic                      last_s1;
	dof_pkg::walk_state_t      state_q;
	dof_pkg::walk_state_t      next_state;
	logic                      res_valid;
	dof_pkg::result_t          res;
	logic                      out_free;
	logic                      advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= dof_pkg::WantedReset;
		end else if (cfg_we) begin
			wanted_q <= cfg_wdata;
		end
	end

	// The byte in the input register moves on unless its result has nowhere to go.
	assign advance = valid_s1 && (!res_valid || out_free);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.option_byte;
			last_s1 <= in_ch.area_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= next_state;
		end
	end

	dof_step u_step (
		.state       (state_q),
		.option_byte (byte_s1),
		.area_last   (last_s1),
		.wanted_code (wanted_q),
		.next_state  (next_state),
		.res_valid   (res_valid),
		.res         (res)
	);

	dof_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res_valid),
		.res    (res),
		.free   (out_free),
		.out_ch (out_ch)
	);

endmodule
